// ===== rtl/core/stok_pkg.sv =====
// types, constants and helper functions shared by the script tokenizer
// depends on nothing
package stok_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 2;
  localparam int unsigned QueueDepthDef = 4;

  localparam logic [ByteW-1:0] CH_NUL    = 8'h00;
  localparam logic [ByteW-1:0] CH_NL     = 8'h0A;
  localparam logic [ByteW-1:0] CH_SPACE  = 8'h20;
  localparam logic [ByteW-1:0] CH_QUOTE  = 8'h22;
  localparam logic [ByteW-1:0] CH_APOS   = 8'h27;
  localparam logic [ByteW-1:0] CH_LPAREN = 8'h28;
  localparam logic [ByteW-1:0] CH_RPAREN = 8'h29;
  localparam logic [ByteW-1:0] CH_STAR   = 8'h2A;
  localparam logic [ByteW-1:0] CH_SLASH  = 8'h2F;
  localparam logic [ByteW-1:0] CH_COLON  = 8'h3A;
  localparam logic [ByteW-1:0] CH_LBRACE = 8'h7B;
  localparam logic [ByteW-1:0] CH_RBRACE = 8'h7D;

  typedef enum logic [KindW-1:0] {
    KIND_WORD    = 2'd0,
    KIND_STRING  = 2'd1,
    KIND_SPECIAL = 2'd2,
    KIND_END     = 2'd3
  } tok_kind_e;

  typedef enum logic [6:0] {
    MODE_IDLE       = 7'b0000001,
    MODE_SLASH      = 7'b0000010,
    MODE_WORD       = 7'b0000100,
    MODE_STRING     = 7'b0001000,
    MODE_BLOCK      = 7'b0010000,
    MODE_BLOCK_STAR = 7'b0100000,
    MODE_LINE       = 7'b1000000
  } mode_e;

  typedef struct packed {
    logic [ByteW-1:0] token_byte;
    tok_kind_e        token_kind;
    logic             first_of_token;
    logic             last_of_token;
    logic             empty_token;
    logic             last_of_burst;
  } tok_rec_t;

  // all results caused by one input byte
  typedef struct packed {
    logic     two;
    tok_rec_t r0;
    tok_rec_t r1;
  } burst_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic tok_rec_t mk_rec(logic [ByteW-1:0] b, tok_kind_e k,
                                      logic f, logic l, logic e);
    tok_rec_t r;
    r.token_byte     = b;
    r.token_kind     = k;
    r.first_of_token = f;
    r.last_of_token  = l;
    r.empty_token    = e;
    r.last_of_burst  = 1'b0;
    return r;
  endfunction

  function automatic logic is_space(logic [ByteW-1:0] b, logic high_sp);
    return ((b >= 8'd1) && (b <= CH_SPACE)) || (b[ByteW-1] && high_sp);
  endfunction

  function automatic logic is_special(logic [ByteW-1:0] b);
    return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_LPAREN) ||
           (b == CH_RPAREN) || (b == CH_APOS) || (b == CH_COLON);
  endfunction

endpackage

// ===== rtl/core/stok_if.sv =====
// channel interfaces of the script tokenizer: text in, tokens out, config
// depends on stok_pkg
interface stok_in_if import stok_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] text_byte;
  logic             end_of_text;
  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

interface stok_out_if import stok_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] token_byte;
  logic [KindW-1:0] token_kind;
  logic             first_of_token;
  logic             last_of_token;
  logic             empty_token;
  logic             last_of_burst;
  modport source (output valid, token_byte, token_kind, first_of_token, last_of_token,
                  empty_token, last_of_burst, input ready);
  modport sink (input valid, token_byte, token_kind, first_of_token, last_of_token,
                empty_token, last_of_burst, output ready);
endinterface

interface stok_cfg_if;
  logic valid;
  logic ready;
  logic high_bytes_as_space;
  modport source (output valid, high_bytes_as_space, input ready);
  modport sink (input valid, high_bytes_as_space, output ready);
endinterface

// ===== rtl/core/stok_front.sv =====
// front end: accepts text bytes, runs the scan mode machine, builds result bursts
// depends on stok_pkg and stok_if
module stok_front import stok_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  stok_in_if.sink        text_i,
  stok_cfg_if.sink       cfg_i,
  input  q_stat_t        q_stat_i,
  output logic           push_o,
  output burst_t         burst_o
);

  logic             high_sp_q;
  mode_e            mode_q, mode_d;
  logic [ByteW-1:0] hchar_q, hchar_d;
  logic             hval_q, hval_d;
  logic             hfirst_q, hfirst_d;

  tok_rec_t         res [2];
  logic [1:0]       nres;
  logic             do_word;
  logic             fire;
  logic             end_in;
  logic [ByteW-1:0] b;

  assign cfg_i.ready  = 1'b1;
  assign text_i.ready = ~q_stat_i.full;
  assign fire   = text_i.valid & text_i.ready;
  assign b      = text_i.text_byte;
  assign end_in = text_i.end_of_text | (b == CH_NUL);

  always_comb begin
    mode_d   = mode_q;
    hchar_d  = hchar_q;
    hval_d   = hval_q;
    hfirst_d = hfirst_q;
    res[0]   = '0;
    res[1]   = '0;
    nres     = 2'd0;
    do_word  = 1'b0;
    if (end_in) begin
      case (mode_q)
        MODE_WORD, MODE_SLASH: begin
          if (hval_q) begin
            res[0] = mk_rec(hchar_q, KIND_WORD, hfirst_q, 1'b1, 1'b0);
            nres   = 2'd1;
          end
        end
        MODE_STRING: begin
          res[0] = hval_q ? mk_rec(hchar_q, KIND_STRING, hfirst_q, 1'b1, 1'b0)
                          : mk_rec(CH_NUL, KIND_STRING, 1'b1, 1'b1, 1'b1);
          nres   = 2'd1;
        end
        default: ;
      endcase
      res[nres[0]] = mk_rec(CH_NUL, KIND_END, 1'b1, 1'b1, 1'b1);
      nres     = nres + 2'd1;
      mode_d   = MODE_IDLE;
      hval_d   = 1'b0;
      hfirst_d = 1'b0;
      hchar_d  = CH_NUL;
    end else begin
      case (mode_q)
        MODE_SLASH: begin
          if (b == CH_STAR || b == CH_SLASH) begin
            hval_d   = 1'b0;
            hfirst_d = 1'b0;
            hchar_d  = CH_NUL;
            mode_d   = (b == CH_STAR) ? MODE_BLOCK : MODE_LINE;
          end else begin
            do_word = 1'b1;
          end
        end
        MODE_WORD: do_word = 1'b1;
        MODE_STRING: begin
          if (b == CH_QUOTE) begin
            res[0] = hval_q ? mk_rec(hchar_q, KIND_STRING, hfirst_q, 1'b1, 1'b0)
                            : mk_rec(CH_NUL, KIND_STRING, 1'b1, 1'b1, 1'b1);
            nres     = 2'd1;
            hval_d   = 1'b0;
            hfirst_d = 1'b0;
            hchar_d  = CH_NUL;
            mode_d   = MODE_IDLE;
          end else begin
            if (hval_q) begin
              res[0] = mk_rec(hchar_q, KIND_STRING, hfirst_q, 1'b0, 1'b0);
              nres   = 2'd1;
            end
            hfirst_d = ~hval_q;
            hval_d   = 1'b1;
            hchar_d  = b;
          end
        end
        MODE_BLOCK: begin
          if (b == CH_STAR) mode_d = MODE_BLOCK_STAR;
        end
        MODE_BLOCK_STAR: begin
          if (b == CH_SLASH) mode_d = MODE_IDLE;
          else if (b != CH_STAR) mode_d = MODE_BLOCK;
        end
        MODE_LINE: begin
          if (b == CH_NL) mode_d = MODE_IDLE;
        end
        default: begin
          mode_d = MODE_IDLE;
          if (!is_space(b, high_sp_q)) begin
            hval_d   = 1'b0;
            hfirst_d = 1'b0;
            hchar_d  = CH_NUL;
            if (b == CH_SLASH) begin
              hchar_d  = b;
              hval_d   = 1'b1;
              hfirst_d = 1'b1;
              mode_d   = MODE_SLASH;
            end else if (b == CH_QUOTE) begin
              mode_d = MODE_STRING;
            end else if (is_special(b)) begin
              res[0] = mk_rec(b, KIND_SPECIAL, 1'b1, 1'b1, 1'b0);
              nres   = 2'd1;
            end else begin
              hchar_d  = b;
              hval_d   = 1'b1;
              hfirst_d = 1'b1;
              mode_d   = MODE_WORD;
            end
          end
        end
      endcase
    end

    // word continuation, shared by word mode and a slash that opens a word
    if (do_word) begin
      if (is_special(b) || is_space(b, high_sp_q)) begin
        if (hval_q) begin
          res[0] = mk_rec(hchar_q, KIND_WORD, hfirst_q, 1'b1, 1'b0);
          nres   = 2'd1;
        end
        if (is_special(b)) begin
          res[nres[0]] = mk_rec(b, KIND_SPECIAL, 1'b1, 1'b1, 1'b0);
          nres         = nres + 2'd1;
        end
        hval_d   = 1'b0;
        hfirst_d = 1'b0;
        hchar_d  = CH_NUL;
        mode_d   = MODE_IDLE;
      end else begin
        if (hval_q) begin
          res[0] = mk_rec(hchar_q, KIND_WORD, hfirst_q, 1'b0, 1'b0);
          nres   = 2'd1;
        end
        hfirst_d = ~hval_q;
        hval_d   = 1'b1;
        hchar_d  = b;
        mode_d   = MODE_WORD;
      end
    end

    if (nres == 2'd1) res[0].last_of_burst = 1'b1;
    if (nres == 2'd2) res[1].last_of_burst = 1'b1;
  end

  assign push_o     = fire & (nres != 2'd0);
  assign burst_o.two = nres[1];
  assign burst_o.r0  = res[0];
  assign burst_o.r1  = res[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_sp_q <= 1'b1;
      mode_q    <= MODE_IDLE;
      hchar_q   <= CH_NUL;
      hval_q    <= 1'b0;
      hfirst_q  <= 1'b0;
    end else begin
      if (cfg_i.valid) high_sp_q <= cfg_i.high_bytes_as_space;
      if (fire) begin
        mode_q   <= mode_d;
        hchar_q  <= hchar_d;
        hval_q   <= hval_d;
        hfirst_q <= hfirst_d;
      end
    end
  end

endmodule

// ===== rtl/core/stok_queue.sv =====
// short burst queue between front and back, flip-flop storage
// depends on stok_pkg
module stok_queue import stok_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  burst_t  burst_i,
  input  logic    pop_i,
  output burst_t  head_o,
  output q_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  burst_t             mem_q [Depth];
  logic [PtrW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]    cnt_q, cnt_d;

  // wrap explicitly so any depth works
  function automatic logic [PtrW-1:0] nxt(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? nxt(wr_q) : wr_q;
    rd_d  = pop_i ? nxt(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + CntW'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= burst_i;
  end

endmodule

// ===== rtl/core/stok_back.sv =====
// back end: unpacks queued bursts into single results in an output register
// depends on stok_pkg and stok_if
module stok_back import stok_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  burst_t    head_i,
  input  q_stat_t   q_stat_i,
  output logic      pop_o,
  stok_out_if.source token_o
);

  logic     ovalid_q;
  tok_rec_t orec_q;
  logic     sub_q;
  logic     load;
  tok_rec_t pick;

  assign load  = ~q_stat_i.empty & (~ovalid_q | token_o.ready);
  assign pick  = sub_q ? head_i.r1 : head_i.r0;
  assign pop_o = load & (~head_i.two | sub_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      sub_q    <= 1'b0;
    end else begin
      if (load) begin
        ovalid_q <= 1'b1;
        sub_q    <= head_i.two & ~sub_q;
      end else if (token_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) orec_q <= pick;
  end

  assign token_o.valid          = ovalid_q;
  assign token_o.token_byte     = orec_q.token_byte;
  assign token_o.token_kind     = orec_q.token_kind;
  assign token_o.first_of_token = orec_q.first_of_token;
  assign token_o.last_of_token  = orec_q.last_of_token;
  assign token_o.empty_token    = orec_q.empty_token;
  assign token_o.last_of_burst  = orec_q.last_of_burst;

endmodule

// ===== rtl/core/script_tokenizer.sv =====
// top level of the script tokenizer: front end, burst queue, back end
// depends on stok_pkg, stok_if, stok_front, stok_queue, stok_back
//
//  channel   dir  handshake     carries
//  text_i    in   valid/ready   text_byte, end_of_text
//  token_o   out  valid/ready   token_byte, token_kind, first/last/empty, last_of_burst
//  cfg_i     in   valid/ready   high_bytes_as_space (always ready)
//
// the front end takes one byte per cycle while the queue has room
// a byte yields zero, one or two results; the back end sends one result per
// cycle while token_o is ready, so a two-result byte sends its results in turn
// the queue holds QueueDepth bursts; text_i.ready drops only when it is full
// a result passes through the queue and the output register on its way to token_o
// reset clears the scan mode, the held character and the queue; the
// whitespace option resets to 1 (high bytes are whitespace)
module script_tokenizer import stok_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  stok_in_if.sink    text_i,
  stok_cfg_if.sink   cfg_i,
  stok_out_if.source token_o
);

  // front to queue
  logic    push;
  burst_t  burst;
  // queue to both sides, and pop from the back end
  q_stat_t q_stat;
  burst_t  head;
  logic    pop;

  // scan mode machine, holds back one character to flag the last one
  stok_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .text_i   (text_i),
    .cfg_i    (cfg_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .burst_o  (burst)
  );

  // decouples byte intake from result delivery
  stok_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .burst_i (burst),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (q_stat)
  );

  // serializes bursts onto the token channel
  stok_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .token_o  (token_o)
  );

endmodule

// ===== rtl/core/stok_checker.sv =====
// port-level checks on the token channel of the script tokenizer, with bind
// depends on stok_pkg and script_tokenizer
module stok_checker import stok_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             valid_i,
  input logic             ready_i,
  input logic [ByteW-1:0] byte_i,
  input logic [KindW-1:0] kind_i,
  input logic             first_i,
  input logic             last_i,
  input logic             empty_i,
  input logic             lob_i
);

  logic             fire;
  logic             mid_q;
  logic [KindW-1:0] kind_q;

  assign fire = valid_i & ready_i;

  // tracks whether a token is open on the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q  <= 1'b0;
      kind_q <= KIND_WORD;
    end else if (fire) begin
      mid_q  <= ~last_i;
      kind_q <= kind_i;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(byte_i) && $stable(kind_i) &&
    $stable(first_i) && $stable(last_i) && $stable(empty_i) && $stable(lob_i))
    else $error("token held under stall changed");

  a_end_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && kind_i == KIND_END |->
    first_i && last_i && empty_i && lob_i && byte_i == CH_NUL)
    else $error("malformed end token");

  a_empty_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && empty_i |-> first_i && last_i &&
    (kind_i == KIND_STRING || kind_i == KIND_END))
    else $error("empty token not a single item");

  a_token_boundary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> first_i == !mid_q)
    else $error("first flag does not match token boundary");

  a_kind_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && mid_q |-> kind_i == kind_q)
    else $error("token kind changed inside a token");

endmodule

bind script_tokenizer stok_checker u_stok_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .valid_i (token_o.valid),
  .ready_i (token_o.ready),
  .byte_i  (token_o.token_byte),
  .kind_i  (token_o.token_kind),
  .first_i (token_o.first_of_token),
  .last_i  (token_o.last_of_token),
  .empty_i (token_o.empty_token),
  .lob_i   (token_o.last_of_burst)
);

// ===== verif/testbench.sv =====
// testbench for script_tokenizer: directed and random script text, checked
// result by result against a token predictor kept inside this file
// depends on stok_pkg, stok_if and the script_tokenizer rtl
module testbench;
  import stok_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        sink_ready = 1'b0;
  bit          steady_flow = 1'b0;
  int unsigned error_count = 0;
  int unsigned bytes_sent = 0;

  stok_in_if  text_if ();
  stok_cfg_if cfg_if ();
  stok_out_if token_if ();

  // token side ready comes from a registered random stall generator
  assign token_if.ready = sink_ready;

  script_tokenizer i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .text_i  (text_if),
    .cfg_i   (cfg_if),
    .token_o (token_if)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // ------------------------------------------------------------------
  // token predictor: its own copy of the option, scan mode and held char
  // ------------------------------------------------------------------
  bit               model_high_sp = 1'b1;
  mode_e            model_mode = MODE_IDLE;
  logic [ByteW-1:0] model_held = '0;
  bit               model_held_valid = 1'b0;
  bit               model_held_first = 1'b0;
  tok_rec_t         step_results[$];
  tok_rec_t         expected_tokens[$];

  function automatic bit is_blank(logic [ByteW-1:0] b);
    return (b != CH_NUL && b <= CH_SPACE) || (b[ByteW-1] && model_high_sp);
  endfunction

  function automatic bit is_punct(logic [ByteW-1:0] b);
    return b == CH_LBRACE || b == CH_RBRACE || b == CH_LPAREN ||
           b == CH_RPAREN || b == CH_APOS || b == CH_COLON;
  endfunction

  function automatic void emit_token(logic [ByteW-1:0] b, tok_kind_e k,
                                     bit first, bit last, bit empty);
    tok_rec_t r;
    r.token_byte     = b;
    r.token_kind     = k;
    r.first_of_token = first;
    r.last_of_token  = last;
    r.empty_token    = empty;
    r.last_of_burst  = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void drop_held();
    model_held       = '0;
    model_held_valid = 1'b0;
    model_held_first = 1'b0;
  endfunction

  // send the held char as the token's last, or an empty string token
  function automatic void close_current(tok_kind_e k);
    if (model_held_valid) begin
      emit_token(model_held, k, model_held_first, 1'b1, 1'b0);
    end else if (k == KIND_STRING) begin
      emit_token(CH_NUL, k, 1'b1, 1'b1, 1'b1);
    end
    drop_held();
    model_mode = MODE_IDLE;
  endfunction

  // a char joins the held back char: the previous one goes out
  function automatic void hold_char(logic [ByteW-1:0] b, tok_kind_e k);
    if (model_held_valid) begin
      emit_token(model_held, k, model_held_first, 1'b0, 1'b0);
    end
    model_held_first = !model_held_valid;
    model_held_valid = 1'b1;
    model_held       = b;
  endfunction

  function automatic void word_char_step(logic [ByteW-1:0] b);
    if (is_punct(b)) begin
      close_current(KIND_WORD);
      emit_token(b, KIND_SPECIAL, 1'b1, 1'b1, 1'b0);
    end else if (is_blank(b)) begin
      close_current(KIND_WORD);
    end else begin
      hold_char(b, KIND_WORD);
      model_mode = MODE_WORD;
    end
  endfunction

  function automatic void idle_char_step(logic [ByteW-1:0] b);
    if (!is_blank(b)) begin
      drop_held();
      if (b == CH_SLASH) begin
        hold_char(b, KIND_WORD);
        model_mode = MODE_SLASH;
      end else if (b == CH_QUOTE) begin
        model_mode = MODE_STRING;
      end else if (is_punct(b)) begin
        emit_token(b, KIND_SPECIAL, 1'b1, 1'b1, 1'b0);
      end else begin
        hold_char(b, KIND_WORD);
        model_mode = MODE_WORD;
      end
    end
  endfunction

  // all tokens one accepted text byte gives, queued in order
  function automatic void predict_tokens(logic [ByteW-1:0] b, logic eot);
    if (eot || b == CH_NUL) begin
      if (model_mode == MODE_WORD || model_mode == MODE_SLASH) begin
        close_current(KIND_WORD);
      end else if (model_mode == MODE_STRING) begin
        close_current(KIND_STRING);
      end
      emit_token(CH_NUL, KIND_END, 1'b1, 1'b1, 1'b1);
      model_mode = MODE_IDLE;
      drop_held();
    end else begin
      case (model_mode)
        MODE_SLASH: begin
          // slash then star or slash opens a comment, else it starts a word
          if (b == CH_STAR) begin
            drop_held();
            model_mode = MODE_BLOCK;
          end else if (b == CH_SLASH) begin
            drop_held();
            model_mode = MODE_LINE;
          end else begin
            word_char_step(b);
          end
        end
        MODE_WORD: begin
          word_char_step(b);
        end
        MODE_STRING: begin
          if (b == CH_QUOTE) begin
            close_current(KIND_STRING);
          end else begin
            hold_char(b, KIND_STRING);
          end
        end
        MODE_BLOCK: begin
          if (b == CH_STAR) model_mode = MODE_BLOCK_STAR;
        end
        MODE_BLOCK_STAR: begin
          if (b == CH_SLASH) begin
            model_mode = MODE_IDLE;
          end else if (b != CH_STAR) begin
            model_mode = MODE_BLOCK;
          end
        end
        MODE_LINE: begin
          if (b == CH_NL) model_mode = MODE_IDLE;
        end
        default: begin
          model_mode = MODE_IDLE;
          idle_char_step(b);
        end
      endcase
    end
    if (step_results.size() > 0) begin
      step_results[step_results.size() - 1].last_of_burst = 1'b1;
    end
    while (step_results.size() > 0) expected_tokens.push_back(step_results.pop_front());
  endfunction

  // ------------------------------------------------------------------
  // monitors: option writes and text transactions feed the predictor,
  // token transactions are compared with the oldest expectation
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && cfg_if.valid && cfg_if.ready) begin
      model_high_sp = cfg_if.high_bytes_as_space;
    end
    if (rst_ni && text_if.valid && text_if.ready) begin
      predict_tokens(text_if.text_byte, text_if.end_of_text);
    end
  end

  function automatic void check_field(string name, logic [ByteW-1:0] want,
                                      logic [ByteW-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    tok_rec_t want;
    if (rst_ni && token_if.valid && token_if.ready) begin
      if (expected_tokens.size() == 0) begin
        $error("token transaction with nothing expected: byte %0h kind %0d",
               token_if.token_byte, token_if.token_kind);
        error_count++;
      end else begin
        want = expected_tokens.pop_front();
        check_field("token_byte", want.token_byte, token_if.token_byte);
        check_field("token_kind", ByteW'(want.token_kind),
                    ByteW'(token_if.token_kind));
        check_field("first_of_token", ByteW'(want.first_of_token),
                    ByteW'(token_if.first_of_token));
        check_field("last_of_token", ByteW'(want.last_of_token),
                    ByteW'(token_if.last_of_token));
        check_field("empty_token", ByteW'(want.empty_token),
                    ByteW'(token_if.empty_token));
        check_field("last_of_burst", ByteW'(want.last_of_burst),
                    ByteW'(token_if.last_of_burst));
      end
    end
  end

  // receiver stalls at random with a chance of 38 in 100, never during a steady stretch
  always @(posedge clk_i) begin
    sink_ready <= steady_flow || ($urandom_range(99) >= 38);
  end

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------

  // one text transaction; valid stays high on return so back-to-back bytes
  // need no second assignment in the same step
  task automatic send_byte(input logic [ByteW-1:0] b, input logic eot);
    while (!steady_flow && $urandom_range(99) < 38) begin
      text_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    text_if.valid       <= 1'b1;
    text_if.text_byte   <= b;
    text_if.end_of_text <= eot;
    do @(posedge clk_i); while (!text_if.ready);
    bytes_sent++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // every token out, then a pause for bytes that give no token
  // valid drops and the clock advances first so the predictor has seen the last text transaction
  task automatic wait_drained();
    text_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic set_high_bytes(input bit as_space);
    wait_drained();
    cfg_if.valid               <= 1'b1;
    cfg_if.high_bytes_as_space <= as_space;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [ByteW-1:0] pick_word_char(bit lead);
    logic [ByteW-1:0] c;
    // a leading slash or quote would open a comment or string instead
    do c = ByteW'($urandom_range(1, 255));
    while (is_blank(c) || is_punct(c) || (lead && (c == CH_SLASH || c == CH_QUOTE)));
    return c;
  endfunction

  function automatic logic [ByteW-1:0] pick_blank();
    case ($urandom_range(3))
      0: return CH_SPACE;
      1: return CH_NL;
      2: return ByteW'($urandom_range(1, 32));
      default: return model_high_sp ? ByteW'($urandom_range(128, 255))
                                    : ByteW'($urandom_range(1, 31));
    endcase
  endfunction

  function automatic logic [ByteW-1:0] pick_punct();
    case ($urandom_range(5))
      0: return CH_LBRACE;
      1: return CH_RBRACE;
      2: return CH_LPAREN;
      3: return CH_RPAREN;
      4: return CH_APOS;
      default: return CH_COLON;
    endcase
  endfunction

  // any nonzero byte except the one that would close the construct
  function automatic logic [ByteW-1:0] pick_inner_char(logic [ByteW-1:0] stop);
    logic [ByteW-1:0] c;
    do c = ByteW'($urandom_range(1, 255));
    while (c == stop);
    return c;
  endfunction

  // one piece of script: mostly well-formed tokens and comments with random
  // content, sometimes unterminated, sometimes a raw byte or an end
  task automatic send_random_piece();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      send_byte(pick_word_char(1'b1), 1'b0);
      repeat ($urandom_range(0, 5)) send_byte(pick_word_char(1'b0), 1'b0);
    end else if (pick < 50) begin
      send_byte(pick_blank(), 1'b0);
    end else if (pick < 62) begin
      send_byte(pick_punct(), 1'b0);
    end else if (pick < 74) begin
      send_byte(CH_QUOTE, 1'b0);
      repeat ($urandom_range(0, 5)) send_byte(pick_inner_char(CH_QUOTE), 1'b0);
      if ($urandom_range(9) != 0) send_byte(CH_QUOTE, 1'b0);
    end else if (pick < 82) begin
      send_string("/*");
      repeat ($urandom_range(0, 5)) begin
        send_byte(($urandom_range(2) == 0) ? CH_STAR : pick_inner_char(CH_STAR), 1'b0);
      end
      if ($urandom_range(9) != 0) send_string("*/");
    end else if (pick < 88) begin
      send_string("//");
      repeat ($urandom_range(0, 5)) send_byte(pick_inner_char(CH_NL), 1'b0);
      send_byte(CH_NL, 1'b0);
    end else if (pick < 95) begin
      send_byte(ByteW'($urandom_range(255)), $urandom_range(7) == 0);
    end else if ($urandom_range(1) == 0) begin
      send_byte(CH_NUL, 1'b0);
    end else begin
      send_byte(ByteW'($urandom_range(255)), 1'b1);
    end
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // single char word closed by a special, all six specials, word closed by a tab
  task automatic test_words_and_specials();
    send_string("a(){}':");
    send_string(" bc\t");
  endtask

  // empty string, then a string cut off by the end flag (byte ignored)
  task automatic test_quoted_strings();
    send_string("\"\"");
    send_string("\"x ");
    send_byte(8'hFF, 1'b1);
  endtask

  // block comment with a doubled star, line comment, slash word ended by a
  // zero byte, block comment ended by end of input
  task automatic test_comments();
    send_string("/***/");
    send_string("//\n");
    send_string("/q");
    send_byte(CH_NUL, 1'b0);
    send_string("/*");
    send_byte(8'h41, 1'b1);
  endtask

  // high bytes as word chars, then as whitespace again
  task automatic test_high_bytes();
    set_high_bytes(1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_SPACE, 1'b0);
    set_high_bytes(1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_NUL, 1'b0);
  endtask

  // four phases alternating the option; the third runs with no idling
  task automatic test_random_scripts();
    int unsigned target;
    for (int p = 0; p < 4; p++) begin
      set_high_bytes(p[0]);
      steady_flow = (p == 2);
      target = bytes_sent + 210;
      while (bytes_sent < target) send_random_piece();
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    text_if.valid              <= 1'b0;
    text_if.text_byte          <= '0;
    text_if.end_of_text        <= 1'b0;
    cfg_if.valid               <= 1'b0;
    cfg_if.high_bytes_as_space <= 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_words_and_specials();
    test_quoted_strings();
    test_comments();
    test_high_bytes();
    test_random_scripts();
    wait_drained();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== script_tokenizer.f =====
rtl/core/stok_pkg.sv
rtl/core/stok_if.sv
rtl/core/stok_front.sv
rtl/core/stok_queue.sv
rtl/core/stok_back.sv
rtl/core/script_tokenizer.sv
rtl/core/stok_checker.sv
verif/testbench.sv
